// ===== design/amgs_pkg.sv =====
// shared types and codes of the adjacency matrix graph store
`timescale 1ns / 1ps
package amgs_pkg;

	localparam int FUNC_W    = 3;
	localparam int LABEL_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int VCOUNT_W  = 4;
	localparam int ECOUNT_W  = 16;
	// widest vertex index over the supported table sizes
	localparam int IDX_MAX_W = 3;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ADD_VERTEX = 3'd0;
	localparam logic [FUNC_W-1:0] FN_EDGE_DIR   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_EDGE_UND   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LIST_DIR   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LIST_UND   = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

	localparam logic [ECOUNT_W-1:0] ECOUNT_MAX = 16'hFFFF;

	// sequencer to storage commands
	typedef struct packed {
		logic                 lab_we;
		logic                 set_en;
		logic [IDX_MAX_W-1:0] wr_idx;
		logic [IDX_MAX_W-1:0] set_col;
		logic [LABEL_W-1:0]   wdata;
		logic [IDX_MAX_W-1:0] lab_ridx;
		logic [IDX_MAX_W-1:0] row_ridx;
	} store_cmd_t;

endpackage

// ===== design/amgs_store.sv =====
// label table and adjacency bit rows, one read port each
`timescale 1ns / 1ps
module amgs_store #(
	parameter int MAX_VERTICES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  amgs_pkg::store_cmd_t        cmd,
	output logic [amgs_pkg::LABEL_W-1:0] lab_rdata,
	output logic [MAX_VERTICES-1:0]     row_rdata
);
	localparam int IW = $clog2(MAX_VERTICES);

	logic [amgs_pkg::LABEL_W-1:0] labels_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]      rows_q   [MAX_VERTICES];

	// label write, no reset: entries are read only once stored
	always_ff @(posedge clk) begin
		if (cmd.lab_we) begin
			labels_q[cmd.wr_idx[IW-1:0]] <= cmd.wdata;
		end
	end

	// adjacency rows, each row sets its own bit on a decode match
	for (genvar r = 0; r < MAX_VERTICES; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[r] <= '0;
			end else if (cmd.set_en && (cmd.wr_idx[IW-1:0] == IW'(r))) begin
				rows_q[r][cmd.set_col[IW-1:0]] <= 1'b1;
			end
		end
	end

	// read ports
	assign lab_rdata = labels_q[cmd.lab_ridx[IW-1:0]];
	assign row_rdata = rows_q[cmd.row_ridx[IW-1:0]];

endmodule

// ===== design/amgs_seq.sv =====
// sequencer with shared label compare and index compare, result register
`timescale 1ns / 1ps
module amgs_seq #(
	parameter int MAX_VERTICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [amgs_pkg::FUNC_W-1:0]   func,
	input  logic [amgs_pkg::LABEL_W-1:0]  label_a,
	input  logic [amgs_pkg::LABEL_W-1:0]  label_b,
	output amgs_pkg::store_cmd_t          cmd,
	input  logic [amgs_pkg::LABEL_W-1:0]  lab_rdata,
	input  logic [MAX_VERTICES-1:0]       row_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [amgs_pkg::STATUS_W-1:0] status,
	output logic                          has_edge,
	output logic [amgs_pkg::LABEL_W-1:0]  row_label,
	output logic [amgs_pkg::LABEL_W-1:0]  col_label,
	output logic [amgs_pkg::VCOUNT_W-1:0] vertex_count,
	output logic [amgs_pkg::ECOUNT_W-1:0] edge_count,
	output logic                          last
);
	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIND_A = 4'd1;
	localparam logic [3:0] S_FIND_B = 4'd2;
	localparam logic [3:0] S_SET_A  = 4'd3;
	localparam logic [3:0] S_SET_B  = 4'd4;
	localparam logic [3:0] S_EMIT   = 4'd5;
	localparam logic [3:0] S_LROW   = 4'd6;
	localparam logic [3:0] S_LCOL   = 4'd7;
	localparam logic [3:0] S_LEND   = 4'd8;

	logic [3:0]                    state_q;
	logic [CW-1:0]                 cnt_q;
	logic [amgs_pkg::ECOUNT_W-1:0] tally_q;
	logic                          pend_v_q;
	logic                          out_valid_q;

	logic [amgs_pkg::FUNC_W-1:0]   func_q;
	logic [amgs_pkg::LABEL_W-1:0]  la_q;
	logic [amgs_pkg::LABEL_W-1:0]  lb_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 j_q;
	logic [IW-1:0]                 a_q;
	logic [IW-1:0]                 b_q;
	logic [amgs_pkg::STATUS_W-1:0] st_q;
	logic [amgs_pkg::LABEL_W-1:0]  row_lab_q;
	logic [amgs_pkg::LABEL_W-1:0]  pend_row_q;
	logic [amgs_pkg::LABEL_W-1:0]  pend_col_q;

	logic [amgs_pkg::STATUS_W-1:0] status_q;
	logic                          has_edge_q;
	logic [amgs_pkg::LABEL_W-1:0]  row_label_q;
	logic [amgs_pkg::LABEL_W-1:0]  col_label_q;
	logic [CW-1:0]                 vcount_q;
	logic [amgs_pkg::ECOUNT_W-1:0] ecount_q;
	logic                          last_q;

	logic                          accept;
	logic                          slot_free;
	logic                          cnt_full;
	logic [amgs_pkg::LABEL_W-1:0]  key;
	logic                          lab_match;
	logic [CW-1:0]                 lim;
	logic [CW-1:0]                 cmp_lhs;
	logic [CW-1:0]                 cmp_rhs;
	logic                          scan_end;
	logic                          edge_bit;
	logic                          lcol_hold;

	logic                          emit;
	logic [amgs_pkg::STATUS_W-1:0] e_status;
	logic                          e_has;
	logic [amgs_pkg::LABEL_W-1:0]  e_row;
	logic [amgs_pkg::LABEL_W-1:0]  e_col;
	logic                          e_last;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign cnt_full  = (cnt_q >= CW'(MAX_VERTICES));

	// shared label compare: first endpoint, then second
	assign key       = (state_q == S_FIND_B) ? lb_q : la_q;
	assign lab_match = (lab_rdata == key);

	// shared index bound compare: table scan or column walk
	assign lim     = (func_q == amgs_pkg::FN_LIST_DIR) ? cnt_q : idx_q;
	assign cmp_lhs = (state_q == S_LCOL) ? j_q : idx_q;
	assign cmp_rhs = (state_q == S_LCOL) ? lim : cnt_q;
	assign scan_end = (cmp_lhs >= cmp_rhs);

	assign edge_bit  = row_rdata[j_q[IW-1:0]];
	// a new pair found while the previous one still cannot leave
	assign lcol_hold = (state_q == S_LCOL) && !scan_end && edge_bit && pend_v_q && !slot_free;

	// storage commands
	always_comb begin
		cmd          = '0;
		cmd.wdata    = label_a;
		cmd.lab_we   = accept && (func == amgs_pkg::FN_ADD_VERTEX) && !cnt_full;
		cmd.set_en   = (state_q == S_SET_A) || (state_q == S_SET_B);
		cmd.lab_ridx = amgs_pkg::IDX_MAX_W'((state_q == S_LCOL) ? j_q[IW-1:0] : idx_q[IW-1:0]);
		cmd.row_ridx = amgs_pkg::IDX_MAX_W'(idx_q[IW-1:0]);
		unique case (state_q)
			S_SET_A: begin
				cmd.wr_idx  = amgs_pkg::IDX_MAX_W'(a_q);
				cmd.set_col = amgs_pkg::IDX_MAX_W'(b_q);
			end
			S_SET_B: begin
				cmd.wr_idx  = amgs_pkg::IDX_MAX_W'(b_q);
				cmd.set_col = amgs_pkg::IDX_MAX_W'(a_q);
			end
			default: begin
				cmd.wr_idx  = amgs_pkg::IDX_MAX_W'(cnt_q[IW-1:0]);
				cmd.set_col = '0;
			end
		endcase
	end

	// result selection
	always_comb begin
		emit     = 1'b0;
		e_status = amgs_pkg::ST_OK;
		e_has    = 1'b0;
		e_row    = '0;
		e_col    = '0;
		e_last   = 1'b1;
		unique case (state_q)
			S_EMIT: begin
				emit     = slot_free;
				e_status = st_q;
			end
			S_LCOL: begin
				emit   = !scan_end && edge_bit && pend_v_q && slot_free;
				e_has  = 1'b1;
				e_row  = pend_row_q;
				e_col  = pend_col_q;
				e_last = 1'b0;
			end
			S_LEND: begin
				emit  = slot_free;
				e_has = pend_v_q;
				e_row = pend_v_q ? pend_row_q : '0;
				e_col = pend_v_q ? pend_col_q : '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			tally_q  <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (func)
							amgs_pkg::FN_ADD_VERTEX: begin
								if (!cnt_full) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= S_EMIT;
							end
							amgs_pkg::FN_EDGE_DIR, amgs_pkg::FN_EDGE_UND: begin
								state_q <= S_FIND_A;
							end
							amgs_pkg::FN_LIST_DIR, amgs_pkg::FN_LIST_UND: begin
								state_q  <= S_LROW;
								pend_v_q <= 1'b0;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_FIND_A: begin
					if (scan_end) begin
						state_q <= S_EMIT;
					end else if (lab_match) begin
						state_q <= S_FIND_B;
					end
				end
				S_FIND_B: begin
					if (scan_end) begin
						state_q <= S_EMIT;
					end else if (lab_match) begin
						state_q <= S_SET_A;
					end
				end
				S_SET_A: begin
					if (tally_q != amgs_pkg::ECOUNT_MAX) begin
						tally_q <= tally_q + amgs_pkg::ECOUNT_W'(1);
					end
					state_q <= (func_q == amgs_pkg::FN_EDGE_UND) ? S_SET_B : S_EMIT;
				end
				S_SET_B: begin
					state_q <= S_EMIT;
				end
				S_LROW: begin
					state_q <= scan_end ? S_LEND : S_LCOL;
				end
				S_LCOL: begin
					if (scan_end) begin
						state_q <= S_LROW;
					end else if (edge_bit && !lcol_hold) begin
						pend_v_q <= 1'b1;
					end
				end
				S_LEND: begin
					if (slot_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_q <= func;
					la_q   <= label_a;
					lb_q   <= label_b;
					idx_q  <= '0;
					st_q   <= ((func == amgs_pkg::FN_ADD_VERTEX) && cnt_full) ?
						amgs_pkg::ST_FULL : amgs_pkg::ST_OK;
				end
			end
			S_FIND_A, S_FIND_B: begin
				if (scan_end) begin
					st_q <= amgs_pkg::ST_UNKNOWN;
				end else if (lab_match) begin
					if (state_q == S_FIND_A) begin
						a_q <= idx_q[IW-1:0];
					end else begin
						b_q <= idx_q[IW-1:0];
					end
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_LROW: begin
				row_lab_q <= lab_rdata;
				j_q       <= '0;
			end
			S_LCOL: begin
				if (scan_end) begin
					idx_q <= idx_q + CW'(1);
				end else if (!lcol_hold) begin
					if (edge_bit) begin
						pend_row_q <= row_lab_q;
						pend_col_q <= lab_rdata;
					end
					j_q <= j_q + CW'(1);
				end
			end
			default: begin
				st_q <= st_q;
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q    <= e_status;
			has_edge_q  <= e_has;
			row_label_q <= e_row;
			col_label_q <= e_col;
			vcount_q    <= cnt_q;
			ecount_q    <= tally_q;
			last_q      <= e_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign has_edge     = has_edge_q;
	assign row_label    = row_label_q;
	assign col_label    = col_label_q;
	assign vertex_count = amgs_pkg::VCOUNT_W'(vcount_q);
	assign edge_count   = ecount_q;
	assign last         = last_q;

endmodule

// ===== design/adjacency_matrix_graph_store_unit.sv =====
// Adjacency matrix graph store: top level.
// An edge add scans the label table for both labels, one table entry compared per cycle
// on the shared compare, and if both are found sets one adjacency bit, or two for undirected.
// A listing walks the matrix one cell per cycle while no found pair waits on a stalled
// result register, directed over all N*N cells and undirected over the cells below
// the diagonal, for N stored vertices; one item at a time.
// arst_n clears vertex count, edge count and all adjacency bits; labels stay undefined.
`timescale 1ns / 1ps
module adjacency_matrix_graph_store_unit #(
	parameter int MAX_VERTICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [amgs_pkg::FUNC_W-1:0]   func,
	input  logic [amgs_pkg::LABEL_W-1:0]  label_a,
	input  logic [amgs_pkg::LABEL_W-1:0]  label_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [amgs_pkg::STATUS_W-1:0] status,
	output logic                          has_edge,
	output logic [amgs_pkg::LABEL_W-1:0]  row_label,
	output logic [amgs_pkg::LABEL_W-1:0]  col_label,
	output logic [amgs_pkg::VCOUNT_W-1:0] vertex_count,
	output logic [amgs_pkg::ECOUNT_W-1:0] edge_count,
	output logic                          last
);
	amgs_pkg::store_cmd_t         cmd;
	logic [amgs_pkg::LABEL_W-1:0] lab_rdata;
	logic [MAX_VERTICES-1:0]      row_rdata;

	// label and adjacency storage
	amgs_store #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.lab_rdata (lab_rdata),
		.row_rdata (row_rdata)
	);

	// sequencer and result register
	amgs_seq #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.label_a      (label_a),
		.label_b      (label_b),
		.cmd          (cmd),
		.lab_rdata    (lab_rdata),
		.row_rdata    (row_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.has_edge     (has_edge),
		.row_label    (row_label),
		.col_label    (col_label),
		.vertex_count (vertex_count),
		.edge_count   (edge_count),
		.last         (last)
	);

endmodule

// ===== design/amgs_checker.sv =====
// port level checks of the graph store, bound to the top level
`timescale 1ns / 1ps
module amgs_checker #(
	parameter int MAX_VERTICES = 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [amgs_pkg::STATUS_W-1:0] status,
	input logic                          has_edge,
	input logic [amgs_pkg::LABEL_W-1:0]  row_label,
	input logic [amgs_pkg::LABEL_W-1:0]  col_label,
	input logic [amgs_pkg::VCOUNT_W-1:0] vertex_count,
	input logic                          last
);
	// a stalled result transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(has_edge)
			&& $stable(row_label) && $stable(col_label) && $stable(last))
		else $error("stalled result changed");

	// one item at a time: busy right after an input transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// results other than listed pairs carry no labels and are marked last
	a_edge_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_edge |-> row_label == '0 && col_label == '0 && last)
		else $error("non-edge result with labels or not last");

	// a listed pair carries status ok
	a_edge_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_edge |-> status == amgs_pkg::ST_OK)
		else $error("listed edge with error status");

	// full status only when the table is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == amgs_pkg::ST_FULL
			|-> vertex_count == amgs_pkg::VCOUNT_W'(MAX_VERTICES))
		else $error("table full reported below capacity");

endmodule

bind adjacency_matrix_graph_store_unit amgs_checker #(
	.MAX_VERTICES(MAX_VERTICES)
) u_amgs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.has_edge     (has_edge),
	.row_label    (row_label),
	.col_label    (col_label),
	.vertex_count (vertex_count),
	.last         (last)
);
